// ===== rtl/dependency_topological_orderer_unit_defines.svh =====
// Assertion macros for the dependency topological orderer.
`ifndef DEPENDENCY_TOPOLOGICAL_ORDERER_UNIT_DEFINES_SVH
`define DEPENDENCY_TOPOLOGICAL_ORDERER_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define DTO_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("orderer check failed");

// Next-cycle implication, checked outside reset.
`define DTO_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("orderer check failed");

`endif

// ===== rtl/dto_pkg.sv =====
// Package: shared types and constants of the dependency topological orderer.
`timescale 1ns / 1ps
package dto_pkg;
	localparam int MAX_MODULES = 16;
	localparam int MAX_DEPS    = 8;
	localparam int ID_BITS     = 16;
	localparam int MAX_RESULTS = 16;
	localparam int IDX_W  = $clog2(MAX_MODULES);
	localparam int CNT_W  = $clog2(MAX_MODULES + 1);
	localparam int DIDX_W = $clog2(MAX_DEPS);
	localparam int DCNT_W = $clog2(MAX_DEPS + 1);
	localparam int RCNT_W = $clog2(MAX_RESULTS + 1);

	localparam logic [1:0] KIND_ADD_MOD = 2'd0;
	localparam logic [1:0] KIND_ADD_DEP = 2'd1;
	localparam logic [1:0] KIND_RESOLVE = 2'd2;

	localparam logic [1:0] DEP_REQUIRED = 2'd0;
	localparam logic [1:0] DEP_OPTIONAL = 2'd1;

	localparam logic [2:0] ST_PLACED   = 3'd0;
	localparam logic [2:0] ST_CYCLE    = 3'd4;
	localparam logic [2:0] ST_OVERFLOW = 3'd5;

	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] ident;
		logic [1:0]  dep_kind;
		logic        dep_null;
	} in_word_t;

	typedef struct packed {
		logic [3:0] module_index;
		logic [2:0] status;
		logic       last;
	} out_word_t;

	typedef struct packed {
		logic [ID_BITS-1:0] target;
		logic [1:0]         kind;
		logic               is_null;
	} dep_rec_t;

	typedef struct packed {
		logic                      id_we;
		logic [IDX_W-1:0]          id_waddr;
		logic [ID_BITS-1:0]        id_wdata;
		logic [IDX_W-1:0]          id_raddr;
		logic                      dep_we;
		logic [IDX_W+DIDX_W-1:0]   dep_waddr;
		dep_rec_t                  dep_wdata;
		logic [IDX_W+DIDX_W-1:0]   dep_raddr;
	} store_req_t;

	typedef struct packed {
		logic             valid;
		logic [IDX_W-1:0] index;
		logic [2:0]       status;
	} push_t;
endpackage

// ===== rtl/dependency_topological_orderer_unit.sv =====
// Top level: load sequencer and Kahn ordering walk over the id and record memories.
`timescale 1ns / 1ps
// Load words (add module, add dependency) are accepted while idle; busy stays low.
// Resolve walks every record, and for each non-null required or optional record
// scans the id memory until its target is found, then for each placed module
// walks the records of every unplaced module still pending, one read at a time
// through the single read port of each memory. Result words leave one per strobe cycle.
// Reset clears the list, counts and flags; memory contents are left as they are.
module dependency_topological_orderer_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  dto_pkg::in_word_t   cmd,
	output logic                strobe,
	output dto_pkg::out_word_t  result
);
	`include "dependency_topological_orderer_unit_defines.svh"

	typedef enum logic [3:0] {
		IDLE, V_MOD, V_DEP, V_DEPW, V_SCAN, V_SCANW,
		P_PICK, P_ID, P_MOD, P_DEP, P_DEPW, C_EMIT, FIN
	} state_t;

	state_t state_q;
	logic [dto_pkg::CNT_W-1:0]  cnt_q;
	logic [dto_pkg::DCNT_W-1:0] depcnt_q [dto_pkg::MAX_MODULES];
	logic [dto_pkg::DCNT_W-1:0] pend_q   [dto_pkg::MAX_MODULES];
	logic [dto_pkg::MAX_MODULES-1:0] placed_q;
	logic [dto_pkg::CNT_W-1:0]  pcount_q;
	logic                       ovf_q;
	logic                       ok_q;
	logic [dto_pkg::CNT_W-1:0]  i_q;
	logic [dto_pkg::DCNT_W-1:0] d_q;
	logic [dto_pkg::CNT_W-1:0]  j_q;
	logic [1:0]                 st_q;
	logic [dto_pkg::DCNT_W-1:0] w_q;
	dto_pkg::dep_rec_t          rec_q;
	logic [dto_pkg::ID_BITS-1:0] pid_q;
	logic                       hit_q;

	dto_pkg::store_req_t req;
	logic [dto_pkg::ID_BITS-1:0] id_rdata;
	dto_pkg::dep_rec_t dep_rdata;
	dto_pkg::push_t push;
	logic flush;
	logic accept;
	logic [dto_pkg::IDX_W-1:0] last_mod;
	logic found;
	logic [dto_pkg::IDX_W-1:0] nxt;

	assign busy     = (state_q != IDLE);
	assign accept   = start && !busy;
	assign last_mod = dto_pkg::IDX_W'(cnt_q - 1'b1);

	// lowest unplaced module whose pending count has drained
	always_comb begin
		found = 1'b0;
		nxt   = '0;
		for (int k = 0; k < dto_pkg::MAX_MODULES; k++) begin
			if (!found && dto_pkg::CNT_W'(k) < cnt_q && !placed_q[k] && pend_q[k] == '0) begin
				found = 1'b1;
				nxt   = dto_pkg::IDX_W'(k);
			end
		end
	end

	// memory requests: writes while loading, reads follow the walk indices
	always_comb begin
		req.id_we     = accept && cmd.kind == dto_pkg::KIND_ADD_MOD &&
		                cnt_q < dto_pkg::CNT_W'(dto_pkg::MAX_MODULES);
		req.id_waddr  = dto_pkg::IDX_W'(cnt_q);
		req.id_wdata  = cmd.ident;
		req.id_raddr  = (state_q == P_PICK) ? nxt : dto_pkg::IDX_W'(j_q);
		req.dep_we    = accept && cmd.kind == dto_pkg::KIND_ADD_DEP && cnt_q != '0 &&
		                depcnt_q[last_mod] < dto_pkg::DCNT_W'(dto_pkg::MAX_DEPS);
		req.dep_waddr = {last_mod, depcnt_q[last_mod][dto_pkg::DIDX_W-1:0]};
		req.dep_wdata = '{target: cmd.ident, kind: cmd.dep_kind, is_null: cmd.dep_null};
		req.dep_raddr = {i_q[dto_pkg::IDX_W-1:0], d_q[dto_pkg::DIDX_W-1:0]};
	end

	// result words handed to the holding stage
	always_comb begin
		push  = '0;
		flush = (state_q == FIN);
		unique case (state_q)
			IDLE: begin
				if (accept && cmd.kind == dto_pkg::KIND_RESOLVE && ovf_q) begin
					push = '{valid: 1'b1, index: '0, status: dto_pkg::ST_OVERFLOW};
				end
			end
			V_DEP: begin
				if (d_q == depcnt_q[i_q[dto_pkg::IDX_W-1:0]] && st_q != 2'd0) begin
					push = '{valid: 1'b1, index: i_q[dto_pkg::IDX_W-1:0], status: {1'b0, st_q}};
				end
			end
			P_PICK: begin
				if (pcount_q != cnt_q && found) begin
					push = '{valid: 1'b1, index: nxt, status: dto_pkg::ST_PLACED};
				end
			end
			C_EMIT: begin
				if (i_q != cnt_q && !placed_q[i_q[dto_pkg::IDX_W-1:0]]) begin
					push = '{valid: 1'b1, index: i_q[dto_pkg::IDX_W-1:0],
					         status: dto_pkg::ST_CYCLE};
				end
			end
			default: push = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= IDLE;
			cnt_q    <= '0;
			placed_q <= '0;
			pcount_q <= '0;
			ovf_q    <= 1'b0;
			ok_q     <= 1'b0;
			i_q      <= '0;
			d_q      <= '0;
			j_q      <= '0;
			st_q     <= '0;
			w_q      <= '0;
			hit_q    <= 1'b0;
			for (int k = 0; k < dto_pkg::MAX_MODULES; k++) begin
				depcnt_q[k] <= '0;
				pend_q[k]   <= '0;
			end
		end else begin
			unique case (state_q)
				IDLE: begin
					if (accept) begin
						priority if (cmd.kind == dto_pkg::KIND_ADD_MOD) begin
							if (cnt_q < dto_pkg::CNT_W'(dto_pkg::MAX_MODULES)) begin
								depcnt_q[dto_pkg::IDX_W'(cnt_q)] <= '0;
								cnt_q <= cnt_q + 1'b1;
							end else begin
								ovf_q <= 1'b1;
							end
						end else if (cmd.kind == dto_pkg::KIND_ADD_DEP) begin
							// drop a record when no module is loaded yet
							if (cnt_q != '0) begin
								if (req.dep_we) begin
									depcnt_q[last_mod] <= depcnt_q[last_mod] + 1'b1;
								end else begin
									ovf_q <= 1'b1;
								end
							end
						end else if (cmd.kind == dto_pkg::KIND_RESOLVE) begin
							i_q  <= '0;
							ok_q <= 1'b1;
							if (ovf_q || cnt_q == '0) begin
								state_q <= FIN;
							end else begin
								state_q <= V_MOD;
							end
						end else begin
							state_q <= IDLE;
						end
					end
				end
				V_MOD: begin
					if (i_q == cnt_q) begin
						pcount_q <= '0;
						placed_q <= '0;
						state_q  <= ok_q ? P_PICK : FIN;
					end else begin
						d_q     <= '0;
						st_q    <= '0;
						w_q     <= '0;
						state_q <= V_DEP;
					end
				end
				V_DEP: begin
					if (d_q == depcnt_q[i_q[dto_pkg::IDX_W-1:0]]) begin
						if (st_q != 2'd0) begin
							ok_q <= 1'b0;
						end
						pend_q[i_q[dto_pkg::IDX_W-1:0]] <= w_q;
						i_q     <= i_q + 1'b1;
						state_q <= V_MOD;
					end else begin
						state_q <= V_DEPW;
					end
				end
				V_DEPW: begin
					rec_q <= dep_rdata;
					if (dep_rdata.is_null) begin
						st_q[0] <= 1'b1;
						d_q     <= d_q + 1'b1;
						state_q <= V_DEP;
					end else if (dep_rdata.kind == dto_pkg::DEP_REQUIRED ||
					             dep_rdata.kind == dto_pkg::DEP_OPTIONAL) begin
						j_q     <= '0;
						state_q <= V_SCAN;
					end else begin
						d_q     <= d_q + 1'b1;
						state_q <= V_DEP;
					end
				end
				V_SCAN: begin
					if (j_q == cnt_q) begin
						// target not loaded: only a required record fails
						if (rec_q.kind == dto_pkg::DEP_REQUIRED) begin
							st_q[1] <= 1'b1;
						end
						d_q     <= d_q + 1'b1;
						state_q <= V_DEP;
					end else begin
						state_q <= V_SCANW;
					end
				end
				V_SCANW: begin
					if (id_rdata == rec_q.target) begin
						w_q     <= w_q + 1'b1;
						d_q     <= d_q + 1'b1;
						state_q <= V_DEP;
					end else begin
						j_q     <= j_q + 1'b1;
						state_q <= V_SCAN;
					end
				end
				P_PICK: begin
					if (pcount_q == cnt_q) begin
						state_q <= FIN;
					end else if (found) begin
						placed_q[nxt] <= 1'b1;
						pcount_q      <= pcount_q + 1'b1;
						state_q       <= P_ID;
					end else begin
						i_q     <= '0;
						state_q <= C_EMIT;
					end
				end
				P_ID: begin
					pid_q   <= id_rdata;
					i_q     <= '0;
					state_q <= P_MOD;
				end
				P_MOD: begin
					if (i_q == cnt_q) begin
						state_q <= P_PICK;
					end else if (placed_q[i_q[dto_pkg::IDX_W-1:0]] ||
					             pend_q[i_q[dto_pkg::IDX_W-1:0]] == '0) begin
						i_q <= i_q + 1'b1;
					end else begin
						d_q     <= '0;
						hit_q   <= 1'b0;
						state_q <= P_DEP;
					end
				end
				P_DEP: begin
					if (d_q == depcnt_q[i_q[dto_pkg::IDX_W-1:0]]) begin
						// decrement once however many records name the placed id
						if (hit_q) begin
							pend_q[i_q[dto_pkg::IDX_W-1:0]] <=
								pend_q[i_q[dto_pkg::IDX_W-1:0]] - 1'b1;
						end
						i_q     <= i_q + 1'b1;
						state_q <= P_MOD;
					end else begin
						state_q <= P_DEPW;
					end
				end
				P_DEPW: begin
					if (!dep_rdata.is_null && dep_rdata.target == pid_q &&
					    (dep_rdata.kind == dto_pkg::DEP_REQUIRED ||
					     dep_rdata.kind == dto_pkg::DEP_OPTIONAL)) begin
						hit_q <= 1'b1;
					end
					d_q     <= d_q + 1'b1;
					state_q <= P_DEP;
				end
				C_EMIT: begin
					if (i_q == cnt_q) begin
						state_q <= FIN;
					end else begin
						i_q <= i_q + 1'b1;
					end
				end
				FIN: begin
					// clear the list for the next load
					cnt_q    <= '0;
					ovf_q    <= 1'b0;
					placed_q <= '0;
					for (int k = 0; k < dto_pkg::MAX_MODULES; k++) begin
						depcnt_q[k] <= '0;
						pend_q[k]   <= '0;
					end
					state_q <= IDLE;
				end
				default: state_q <= IDLE;
			endcase
		end
	end

	dto_store u_store (
		.clk       (clk),
		.req       (req),
		.id_rdata  (id_rdata),
		.dep_rdata (dep_rdata)
	);

	dto_emit u_emit (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.flush  (flush),
		.strobe (strobe),
		.result (result)
	);

	`DTO_ASSERT_NEXT(a_last_ends_run, strobe && result.last, !strobe)
	`DTO_ASSERT_NOW(a_overflow_alone, strobe && result.status == dto_pkg::ST_OVERFLOW,
		result.last && result.module_index == 4'd0)
	`DTO_ASSERT_NEXT(a_load_one_cycle, start && !busy && cmd.kind != dto_pkg::KIND_RESOLVE,
		!busy)
endmodule

// ===== rtl/dto_store.sv =====
// Module id memory and dependency record memory, registered synchronous reads.
`timescale 1ns / 1ps
module dto_store (
	input  logic                clk,
	input  dto_pkg::store_req_t req,
	output logic [dto_pkg::ID_BITS-1:0] id_rdata,
	output dto_pkg::dep_rec_t   dep_rdata
);
	logic [dto_pkg::ID_BITS-1:0] id_mem [dto_pkg::MAX_MODULES];
	dto_pkg::dep_rec_t dep_mem [dto_pkg::MAX_MODULES * dto_pkg::MAX_DEPS];

	always_ff @(posedge clk) begin
		if (req.id_we) begin
			id_mem[req.id_waddr] <= req.id_wdata;
		end
		id_rdata <= id_mem[req.id_raddr];
	end

	always_ff @(posedge clk) begin
		if (req.dep_we) begin
			dep_mem[req.dep_waddr] <= req.dep_wdata;
		end
		dep_rdata <= dep_mem[req.dep_raddr];
	end
endmodule

// ===== rtl/dto_emit.sv =====
// Result holding stage: holds each word until the next one arrives so the final one carries last.
`timescale 1ns / 1ps
module dto_emit (
	input  logic               clk,
	input  logic               arst_n,
	input  dto_pkg::push_t     push,
	input  logic               flush,
	output logic               strobe,
	output dto_pkg::out_word_t result
);
	logic                          hold_v_q;
	logic [dto_pkg::IDX_W-1:0]     hold_idx_q;
	logic [2:0]                    hold_st_q;
	logic [dto_pkg::RCNT_W-1:0]    pc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_v_q <= 1'b0;
			pc_q     <= '0;
			strobe   <= 1'b0;
		end else begin
			strobe <= 1'b0;
			if (flush) begin
				// release the held word as the final one
				strobe   <= hold_v_q;
				hold_v_q <= 1'b0;
				pc_q     <= '0;
				result   <= '{module_index: 4'(hold_idx_q), status: hold_st_q, last: 1'b1};
			end else if (push.valid && pc_q < dto_pkg::RCNT_W'(dto_pkg::MAX_RESULTS)) begin
				strobe     <= hold_v_q;
				result     <= '{module_index: 4'(hold_idx_q), status: hold_st_q, last: 1'b0};
				hold_v_q   <= 1'b1;
				hold_idx_q <= push.index;
				hold_st_q  <= push.status;
				pc_q       <= pc_q + 1'b1;
			end
		end
	end
endmodule
